/* rtl/bdh_pkg.sv */
// Shared types and constants for the button debounce / hold detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bdh_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_W     = 3;
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int MASK_W   = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_LIMIT      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_ENABLE  = 8'd3;

   localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 16'd20;
   localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 16'd1000;

   typedef struct packed {
      logic [LIMIT_W-1:0] debounce_limit;
      logic [LIMIT_W-1:0] hold_limit;
      logic [MASK_W-1:0]  active_low_mask;
      logic [MASK_W-1:0]  channel_enable;
   } cfg_type;

   typedef struct packed {
      logic deb_run;
      logic hold_run;
      logic pressed;
      logic held;
   } flags_type;

endpackage
`default_nettype wire

/* rtl/button_debounce_hold_detector.sv */
// Top level of the multi-channel button debounce / long-press detector.
// Depends on bdh_pkg, bdh_csr, bdh_chan_state.
`timescale 1ns / 1ps
`default_nettype none
// Each req beat is one poll of one button: channel, raw pin level and a
// millisecond timestamp (wrapping modulo 2^32). Every poll yields exactly
// one rsp beat carrying the channel and its debounced pressed / long-press
// state after that poll. A press or release counts once the level has
// lasted debounce_limit ms; long_press sets once pressed for hold_limit ms.
// Disabled channels report zeros and keep their state. One poll per cycle
// is sustained while rsp_stall is low, also on the same channel, since the
// per-channel state lives in flip-flops read and rewritten in the same
// cycle. rsp_stall holds the result register and backs up into req_stall
// once the input register is full.
// Registers (csr_index): 0 debounce_limit, 1 hold_limit, 2 active_low_mask,
// 3 channel_enable; other indices are ignored. csr_ready is always high;
// write only while no poll is in flight.
module button_debounce_hold_detector import bdh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // poll channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CH_W-1:0]       req_channel,
   input  wire logic                  req_pin_level,
   input  wire logic [TIME_W-1:0]     req_now_ms,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [CH_W-1:0]            rsp_channel_out,
   output logic                       rsp_pressed,
   output logic                       rsp_long_press,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0]   s1_channel_ff;
   logic              s1_pin_ff;
   logic [TIME_W-1:0] s1_now_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [CH_W-1:0]   out_channel_ff;
   logic              out_pressed_ff;
   logic              out_long_ff;

   logic advance;     // poll in s1 moves to the result register
   logic req_take;
   logic nx_pressed;
   logic nx_long;

   assign csr_ready = 1'b1;

   bdh_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   bdh_chan_state u_state (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .upd        (advance),
      .channel    (s1_channel_ff),
      .pin_level  (s1_pin_ff),
      .now_ms     (s1_now_ff),
      .pressed    (nx_pressed),
      .long_press (nx_long)
   );

   // result slot is free when empty or being taken this cycle
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_channel_ff <= req_channel;
         s1_pin_ff     <= req_pin_level;
         s1_now_ff     <= req_now_ms;
      end
      if (advance) begin
         out_channel_ff <= s1_channel_ff;
         out_pressed_ff <= nx_pressed;
         out_long_ff    <= nx_long;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_channel_out = out_channel_ff;
   assign rsp_pressed     = out_pressed_ff;
   assign rsp_long_press  = out_long_ff;

endmodule
`default_nettype wire

/* rtl/bdh_csr.sv */
// Configuration registers of the debounce / hold detector.
// Depends on bdh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdh_csr import bdh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_DEBOUNCE_LIMIT:  cfg_in.debounce_limit  = wr_data[LIMIT_W-1:0];
            REG_HOLD_LIMIT:      cfg_in.hold_limit      = wr_data[LIMIT_W-1:0];
            REG_ACTIVE_LOW_MASK: cfg_in.active_low_mask = wr_data[MASK_W-1:0];
            REG_CHANNEL_ENABLE:  cfg_in.channel_enable  = wr_data[MASK_W-1:0];
            default:             cfg_in = cfg_ff;  // unmapped: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit  <= DEBOUNCE_LIMIT_RST;
         cfg_ff.hold_limit      <= HOLD_LIMIT_RST;
         cfg_ff.active_low_mask <= '0;
         cfg_ff.channel_enable  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/bdh_chan_state.sv */
// Per-channel debounce / hold state and its single-pass update.
// Depends on bdh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdh_chan_state import bdh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              upd,      // commit this poll
   input  wire logic [CH_W-1:0]   channel,
   input  wire logic              pin_level,
   input  wire logic [TIME_W-1:0] now_ms,
   output logic                   pressed,
   output logic                   long_press
);

   flags_type         flags_ff [CHANNELS];
   logic [TIME_W-1:0] deb_start_ff [CHANNELS];
   logic [TIME_W-1:0] hold_start_ff [CHANNELS];

   flags_type         flags_in;
   logic [TIME_W-1:0] deb_start_in;
   logic [TIME_W-1:0] hold_start_in;
   logic              enabled;

   // Both elapsed compares work off stored start times; a timer started in
   // this poll has zero elapsed, so only a zero limit completes it.
   always_comb begin
      flags_type         f;
      logic [TIME_W-1:0] ds;
      logic [TIME_W-1:0] hs;
      logic              active;
      logic              deb_done;
      logic              hold_done;
      logic              deb_zero;
      logic              hold_zero;

      enabled = ({1'b0, channel} < (CH_W+1)'(CHANNELS)) && cfg.channel_enable[channel];
      f       = flags_ff[channel];
      ds      = deb_start_ff[channel];
      hs      = hold_start_ff[channel];
      active  = pin_level ^ cfg.active_low_mask[channel];
      deb_done  = (now_ms - ds) >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.debounce_limit};
      hold_done = (now_ms - hs) >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.hold_limit};
      deb_zero  = (cfg.debounce_limit == '0);
      hold_zero = (cfg.hold_limit == '0);

      // press debounce
      if (!f.pressed) begin
         if (active) begin
            if (f.deb_run ? deb_done : deb_zero) begin
               f.pressed = 1'b1;
               f.deb_run = 1'b0;
            end else begin
               if (!f.deb_run) ds = now_ms;
               f.deb_run = 1'b1;
            end
         end else begin
            f.deb_run = 1'b0;
         end
      end

      // hold timing
      if (f.pressed && !f.held) begin
         if (active) begin
            if (f.hold_run ? hold_done : hold_zero) begin
               f.held     = 1'b1;
               f.hold_run = 1'b0;
            end else begin
               if (!f.hold_run) hs = now_ms;
               f.hold_run = 1'b1;
            end
         end else begin
            f.hold_run = 1'b0;
         end
      end

      // release debounce; deb_run here is never one set by the press step
      if (f.pressed) begin
         if (!active) begin
            if (f.deb_run ? deb_done : deb_zero) begin
               f = '0;
            end else begin
               if (!f.deb_run) ds = now_ms;
               f.deb_run = 1'b1;
            end
         end else begin
            f.deb_run = 1'b0;
         end
      end

      flags_in      = f;
      deb_start_in  = ds;
      hold_start_in = hs;
      pressed       = enabled && f.pressed;
      long_press    = enabled && f.held;
   end

   // start times are only read while their run flag is set: no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) flags_ff[i] <= '0;
      end else if (upd && enabled) begin
         flags_ff[channel] <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd && enabled) begin
         deb_start_ff[channel]  <= deb_start_in;
         hold_start_ff[channel] <= hold_start_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/bdh_checker.sv */
// Port-level checks for the debounce / hold detector, bound to the top.
// Depends on bdh_pkg and button_debounce_hold_detector.
`timescale 1ns / 1ps
`default_nettype none
module bdh_checker import bdh_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [CH_W-1:0]   rsp_channel_out,
   input wire logic              rsp_pressed,
   input wire logic              rsp_long_press
);

   // no result beat straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // long press only ever reported on a pressed button
   a_long_implies_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_long_press || rsp_pressed))
      else $error("long_press without pressed");

   // with an empty result register the input side never stalls
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall with no result pending");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_pressed) && $stable(rsp_long_press))
      else $error("stalled rsp beat changed");

endmodule

bind button_debounce_hold_detector bdh_checker u_bdh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_channel_out (rsp_channel_out),
   .rsp_pressed     (rsp_pressed),
   .rsp_long_press  (rsp_long_press)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for button_debounce_hold_detector: directed polls, then random ones.
// Depends on bdh_pkg and the detector RTL. Expected results come from its own button model.
`timescale 1ns / 1ps
module tb_top;
   import bdh_pkg::*;

   // Index outside the register map: the write must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 8'hC3;
   localparam int TAIL_CYCLES = 6;     // idle tail after the last result has arrived
   localparam int LONG_HOLD   = 60;    // receiver hold-off, long enough to back up req
   localparam int PHASES      = 6;
   localparam int PHASE_POLLS = 125;

   // One result beat as the block reports it.
   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic            pressed;
      logic            long_press;
   } button_status_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks per-channel debounce/hold state and the results due.
   // -------------------------------------------------------------------------
   class button_scoreboard;
      cfg_type           regs;
      flags_type         flg     [CHANNELS];
      logic [TIME_W-1:0] deb_t0  [CHANNELS];
      logic [TIME_W-1:0] hold_t0 [CHANNELS];
      button_status_type status_due[$];
      int                errors;

      function new();
         regs.debounce_limit  = DEBOUNCE_LIMIT_RST;
         regs.hold_limit      = HOLD_LIMIT_RST;
         regs.active_low_mask = '0;
         regs.channel_enable  = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            flg[c]     = '0;
            deb_t0[c]  = '0;
            hold_t0[c] = '0;
         end
         errors = 0;
      endfunction

      task report(string msg);
         if (errors < 50)
            $display("tb_top: %0t ns: %s", $time, msg);
         errors++;
      endtask

      // Elapsed time wraps modulo 2^32; limit is zero-extended.
      function bit lapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] t0,
                          logic [LIMIT_W-1:0] lim);
         logic [TIME_W-1:0] el;
         el = now - t0;
         return el >= {{(TIME_W-LIMIT_W){1'b0}}, lim};
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_DEBOUNCE_LIMIT:  regs.debounce_limit  = d[LIMIT_W-1:0];
            REG_HOLD_LIMIT:      regs.hold_limit      = d[LIMIT_W-1:0];
            REG_ACTIVE_LOW_MASK: regs.active_low_mask = d[MASK_W-1:0];
            REG_CHANNEL_ENABLE:  regs.channel_enable  = d[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance one channel by one poll and queue the status it must report.
      function void note_poll(logic [CH_W-1:0] ch, logic pin, logic [TIME_W-1:0] now);
         flags_type         f;
         logic              act;
         button_status_type s;
         s.channel    = ch;
         s.pressed    = 1'b0;
         s.long_press = 1'b0;
         if (regs.channel_enable[ch]) begin
            act = pin ^ regs.active_low_mask[ch];
            f   = flg[ch];
            // press debounce
            if (!f.pressed) begin
               if (act) begin
                  if (!f.deb_run) begin
                     f.deb_run  = 1'b1;
                     deb_t0[ch] = now;
                  end
                  if (lapsed(now, deb_t0[ch], regs.debounce_limit)) begin
                     f.pressed = 1'b1;
                     f.deb_run = 1'b0;
                  end
               end else if (f.deb_run) begin
                  f.deb_run  = 1'b0;
                  deb_t0[ch] = '0;
               end
            end
            // hold timing, may follow a press in the same poll
            if (f.pressed && !f.held) begin
               if (act) begin
                  if (!f.hold_run) begin
                     f.hold_run  = 1'b1;
                     hold_t0[ch] = now;
                  end
                  if (lapsed(now, hold_t0[ch], regs.hold_limit)) begin
                     f.held     = 1'b1;
                     f.hold_run = 1'b0;
                  end
               end else if (f.hold_run) begin
                  f.hold_run  = 1'b0;
                  hold_t0[ch] = '0;
               end
            end
            // release debounce; hold start time is kept on release
            if (f.pressed) begin
               if (!act) begin
                  if (!f.deb_run) begin
                     f.deb_run  = 1'b1;
                     deb_t0[ch] = now;
                  end
                  if (lapsed(now, deb_t0[ch], regs.debounce_limit))
                     f = '0;
               end else if (f.deb_run) begin
                  f.deb_run  = 1'b0;
                  deb_t0[ch] = '0;
               end
            end
            flg[ch]      = f;
            s.pressed    = f.pressed;
            s.long_press = f.held;
         end
         status_due.push_back(s);
      endfunction

      task check_status(logic [CH_W-1:0] ch, logic pr, logic lp);
         button_status_type s;
         if (status_due.size() == 0) begin
            report($sformatf("result beat with nothing due: ch %0d", ch));
         end else begin
            s = status_due.pop_front();
            if (ch !== s.channel)
               report($sformatf("channel_out %0d, want %0d", ch, s.channel));
            if (pr !== s.pressed)
               report($sformatf("ch %0d pressed %b, want %b", s.channel, pr, s.pressed));
            if (lp !== s.long_press)
               report($sformatf("ch %0d long_press %b, want %b", s.channel, lp, s.long_press));
         end
      endtask

      function int pending();
         return status_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_channel = '0;
   logic                  req_pin_level = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_channel_out;
   logic                  rsp_pressed;
   logic                  rsp_long_press;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #4 clock = ~clock;

   button_debounce_hold_detector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_pin_level   (req_pin_level),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_pressed     (rsp_pressed),
      .rsp_long_press  (rsp_long_press),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   button_scoreboard sb = new();

   // Idle rates in percent, changed per phase.
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;

   // Long receiver hold-off: the main flow toggles hold_kick, this process
   // counts the stretch down on its own.
   logic        hold_kick = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: stall at random, or solidly during a hold-off.
   always @(posedge clock) begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(99, 0) < rx_idle_pct);
   end

   // Result monitor: a beat moves when valid is high and we are not stalling.
   // Values read here are the pre-edge ones, so no race with the DUT's flops.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_status(rsp_channel_out, rsp_pressed, rsp_long_press);
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Current settings, mirrored for shaping the random polls.
   int unsigned       cur_deb    = DEBOUNCE_LIMIT_RST;
   int unsigned       cur_hold   = HOLD_LIMIT_RST;
   logic [MASK_W-1:0] cur_enable = '0;

   // Per channel: running timestamp and the level the "finger" is holding.
   logic [TIME_W-1:0] chan_ms    [CHANNELS];
   logic              chan_level [CHANNELS];

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, d);
   endtask

   task automatic apply_settings(logic [CSR_DATA_W-1:0] deb, logic [CSR_DATA_W-1:0] hold,
                                 logic [CSR_DATA_W-1:0] mask, logic [CSR_DATA_W-1:0] en);
      write_csr(REG_DEBOUNCE_LIMIT, deb);
      write_csr(REG_HOLD_LIMIT, hold);
      write_csr(REG_ACTIVE_LOW_MASK, mask);
      write_csr(REG_CHANNEL_ENABLE, en);
      cur_deb    = deb[LIMIT_W-1:0];
      cur_hold   = hold[LIMIT_W-1:0];
      cur_enable = en[MASK_W-1:0];
   endtask

   // One poll beat; an optional idle gap in front, then hold until accepted.
   task automatic send_poll(logic [CH_W-1:0] ch, logic pin, logic [TIME_W-1:0] now);
      if ($urandom_range(99, 0) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_channel   <= ch;
      req_pin_level <= pin;
      req_now_ms    <= now;
      do @(posedge clock); while (req_stall);
      sb.note_poll(ch, pin, now);
   endtask

   // Stop offering, let every due result arrive, then a short tail.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly plausible button traffic: per channel time runs forward and the
   // level is held for stretches with the odd bounce; some polls are noise.
   task automatic random_polls(int unsigned count);
      int unsigned ch;
      int unsigned step;
      logic        pin;
      for (int unsigned n = 0; n < count; n++) begin
         ch = $urandom_range(CHANNELS - 1, 0);
         if (cur_enable != '0 && $urandom_range(99, 0) < 85)
            while (!cur_enable[ch]) ch = $urandom_range(CHANNELS - 1, 0);
         if ($urandom_range(99, 0) < 8) begin
            send_poll(ch[CH_W-1:0], 1'($urandom_range(1, 0)), $urandom());
         end else begin
            if ($urandom_range(99, 0) < 6)
               chan_level[ch] = ~chan_level[ch];
            // small steps for debounce, occasional big jumps to reach hold
            if ($urandom_range(99, 0) < 12)
               step = $urandom_range(cur_deb + cur_hold + 2, 0);
            else
               step = $urandom_range(cur_deb / 3 + 2, 0);
            chan_ms[ch] = chan_ms[ch] + step;
            pin = chan_level[ch];
            if ($urandom_range(99, 0) < 7)
               pin = ~pin;
            send_poll(ch[CH_W-1:0], pin, chan_ms[ch]);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main flow
   // -------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct <= 25;
      rx_idle_pct <= 81;

      // Reset settings: all channels disabled, so zeros whatever the pin.
      send_poll(3'd0, 1'b1, 32'h0000_0000);
      send_poll(3'd5, 1'b0, 32'hFFFF_FFFF);
      settle();

      // Debounce 5, hold 10; channels 0-3 active low; channel 7 off.
      // Upper data bits of the 8-bit registers must be dropped.
      apply_settings(16'd5, 16'd10, 16'hFF0F, 16'hA57F);
      write_csr(REG_UNMAPPED, 16'hFFFF);
      send_poll(3'd7, 1'b1, 32'd100);       // disabled channel
      // channel 0: press, bounces, hold, release
      send_poll(3'd0, 1'b0, 32'd100);       // debounce starts
      send_poll(3'd0, 1'b0, 32'd104);       // one short of the limit
      send_poll(3'd0, 1'b0, 32'd105);       // pressed, hold timer starts
      send_poll(3'd0, 1'b1, 32'd108);       // hold stops, release debounce starts
      send_poll(3'd0, 1'b0, 32'd110);       // release interrupted, hold restarts
      send_poll(3'd0, 1'b1, 32'd111);       // bounce
      send_poll(3'd0, 1'b0, 32'd112);       // hold restarts at 112
      send_poll(3'd0, 1'b0, 32'd122);       // held
      send_poll(3'd0, 1'b1, 32'd123);       // release debounce while held
      send_poll(3'd0, 1'b1, 32'd128);       // released
      // channel 4 active high: debounce across the timestamp wrap
      send_poll(3'd4, 1'b1, 32'hFFFF_FFFE);
      send_poll(3'd4, 1'b1, 32'h0000_0003);
      // channel 5: press debounce interrupted and restarted
      send_poll(3'd5, 1'b1, 32'd200);
      send_poll(3'd5, 1'b0, 32'd202);
      send_poll(3'd5, 1'b1, 32'd204);
      send_poll(3'd5, 1'b1, 32'd208);
      settle();

      // Zero limits: press and hold in one poll, release in the next.
      apply_settings(16'd0, 16'd0, 16'h000F, 16'h00FF);
      send_poll(3'd1, 1'b0, 32'd7);
      send_poll(3'd1, 1'b1, 32'd7);
      settle();

      // Largest limits.
      apply_settings(16'hFFFF, 16'hFFFF, 16'h000F, 16'h00FF);
      send_poll(3'd2, 1'b0, 32'd0);
      send_poll(3'd2, 1'b0, 32'd65535);     // pressed
      send_poll(3'd2, 1'b0, 32'd131069);    // hold one short
      send_poll(3'd2, 1'b0, 32'd131070);    // held
      settle();

      for (int c = 0; c < CHANNELS; c++) begin
         chan_ms[c]    = $urandom();
         chan_level[c] = 1'($urandom_range(1, 0));
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(16'd10, 16'd40, 16'h005A, 16'h00FF);
            1: apply_settings(16'd0, 16'd0, 16'h00FF, 16'h00F0);
            2: apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF);
            4: apply_settings(16'd30, 16'd0, 16'h0033, 16'h00CF);
            default: apply_settings(16'($urandom_range(60, 0)), 16'($urandom_range(300, 0)),
                                    16'($urandom_range(255, 0)), 16'($urandom_range(255, 1)));
         endcase
         // idling: sender light / receiver heavy, then swapped, then none
         if (p < 2) begin
            tx_idle_pct <= 25;
            rx_idle_pct <= 81;
         end else if (p < 4) begin
            tx_idle_pct <= 81;
            rx_idle_pct <= 25;
         end else begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end
         // big limits: start timestamps just below the wrap
         if (p == 2)
            for (int c = 0; c < CHANNELS; c++)
               chan_ms[c] = 32'hFFFF_0000 + $urandom_range(32'hFFFF, 0);
         // receiver blocks for a while so the pipe fills and req stalls
         if (p == 0 || p == 4)
            hold_kick <= ~hold_kick;
         random_polls(PHASE_POLLS);
         settle();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
